// ===== hdl/ace_pkg.sv =====
// shared types, constants and codes of the apdu chaining engine
package ace_pkg;

  localparam int unsigned CHAINED_CAPACITY_DEF = 4096;

  // input actions
  localparam logic [1:0] ACT_START    = 2'd0;
  localparam logic [1:0] ACT_MSG_BYTE = 2'd1;
  localparam logic [1:0] ACT_RSP_BYTE = 2'd2;
  localparam logic [1:0] ACT_RSP_END  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // status codes
  localparam logic [2:0] ST_ACKED    = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_GETRSP   = 3'd2;
  localparam logic [2:0] ST_BAD_CFG  = 3'd3;
  localparam logic [2:0] ST_LINK     = 3'd4;
  localparam logic [2:0] ST_BAD_SW   = 3'd5;
  localparam logic [2:0] ST_TOO_LONG = 3'd6;

  // register indexes
  localparam logic REG_MAX_TX = 1'b0;
  localparam logic REG_MAX_RX = 1'b1;

  // apdu bytes
  localparam logic [7:0] CLA_LAST  = 8'h80;
  localparam logic [7:0] CLA_CHAIN = 8'h90;
  localparam logic [7:0] INS_XFER  = 8'h20;
  localparam logic [7:0] INS_GET   = 8'hC0;
  localparam logic [7:0] SW1_MORE  = 8'h61;
  localparam logic [7:0] SW1_OK    = 8'h90;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  // room for up to seven results per item
  localparam int unsigned MAX_RES = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [2:0] status;
  } res_t;

  // one work entry between front and back
  typedef struct packed {
    logic [2:0]           count;
    res_t [MAX_RES-1:0]   res;
  } job_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_COLLECT  = 4'b0010,
    PH_WAIT_CHK = 4'b0100,
    PH_WAIT_GET = 4'b1000
  } phase_e;

  function automatic res_t mk(logic [1:0] k, logic [7:0] b, logic l, logic [2:0] s);
    res_t r;
    r.kind = k;
    r.data = b;
    r.last = l;
    r.status = s;
    return r;
  endfunction

endpackage

// ===== hdl/apdu_chaining_engine_top.sv =====
// Top level of the apdu chaining engine. One input transfer is taken per cycle while
// the two-entry job queue has room; each item yields up to six output transfers,
// sent one per cycle by the back serializer while the output is ready, so sustained
// rate is set by the results per item; items with no result take no queue entry.
module apdu_chaining_engine_top #(
  parameter int unsigned ChainedCapacity = ace_pkg::CHAINED_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_byte, message_length, transport_ok, zeros
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast,  // out_last
  output logic [4:0]  m_axis_tuser   // out_kind, status
);
  import ace_pkg::*;

  logic jv, jr;
  job_t job;
  res_t res;

  ace_front #(.ChainedCapacity(ChainedCapacity)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .action_i(s_axis_tuser), .data_byte_i(s_axis_tdata[7:0]),
    .message_length_i(s_axis_tdata[23:8]), .transport_ok_i(s_axis_tdata[24]),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  ace_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tlast = res.last;
  assign m_axis_tuser = {res.status, res.kind};

endmodule

// ===== hdl/ace_front.sv =====
// front part: model state, classifies each item into a batch of results
module ace_front #(
  parameter int unsigned ChainedCapacity = ace_pkg::CHAINED_CAPACITY_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      action_i,
  input  logic [7:0]      data_byte_i,
  input  logic [15:0]     message_length_i,
  input  logic            transport_ok_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output ace_pkg::job_t   job_o
);
  import ace_pkg::*;

  localparam int unsigned CntW = $clog2(ChainedCapacity + 1);

  logic [7:0] max_tx_q, max_rx_q;
  phase_e     phase_q, phase_d;
  logic [15:0] total_q, total_d, sent_q, sent_d;
  logic [7:0] left_q, left_d;
  logic       lastc_q, lastc_d;
  logic [7:0] h0_q, h0_d, h1_q, h1_d;
  logic [1:0] hcnt_q, hcnt_d;
  logic [CntW-1:0] ccnt_q, ccnt_d;
  job_t       job;
  logic       fire;

  assign in_ready_o  = job_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign job_valid_o = fire && (job.count != 3'd0);
  assign job_o       = job;

  // item classification, mirrors the chaining protocol
  always_comb begin
    logic [15:0] rem;
    logic [7:0]  chunk;
    logic        lc;
    logic [7:0]  le;
    logic        ok;
    logic        sc;
    logic [2:0]  n;
    phase_d = phase_q;
    total_d = total_q;
    sent_d  = sent_q;
    left_d  = left_q;
    lastc_d = lastc_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    hcnt_d  = hcnt_q;
    ccnt_d  = ccnt_q;
    job     = '0;
    n       = 3'd0;
    sc      = 1'b0;
    rem     = '0;
    chunk   = '0;
    lc      = 1'b0;
    le      = '0;
    ok      = 1'b0;
    unique case (action_i)
      ACT_START: begin
        hcnt_d  = 2'd0;
        ccnt_d  = '0;
        sent_d  = '0;
        total_d = message_length_i;
        if (max_tx_q == 8'd0 || max_rx_q == 8'd0 || message_length_i == 16'd0) begin
          phase_d = PH_IDLE;
          job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b1, ST_BAD_CFG);
          n = 3'd1;
        end else begin
          sc = 1'b1;
        end
      end
      ACT_MSG_BYTE: begin
        if (phase_q == PH_COLLECT) begin
          sent_d = sent_q + 16'd1;
          left_d = (left_q != 8'd0) ? left_q - 8'd1 : left_q;
          job.res[0] = mk(KIND_FRAME, data_byte_i, 1'b0, ST_ACKED);
          n = 3'd1;
          if (left_d == 8'd0) begin
            job.res[1] = mk(KIND_FRAME, max_rx_q, 1'b1, ST_ACKED);
            n = 3'd2;
            phase_d = PH_WAIT_CHK;
            hcnt_d = 2'd0;
          end
        end
      end
      ACT_RSP_BYTE: begin
        if (phase_q == PH_WAIT_CHK || phase_q == PH_WAIT_GET) begin
          if (hcnt_q == 2'd0) begin
            h0_d = data_byte_i;
            hcnt_d = 2'd1;
          end else if (hcnt_q == 2'd1) begin
            h1_d = data_byte_i;
            hcnt_d = 2'd2;
          end else begin
            h0_d = h1_q;
            h1_d = data_byte_i;
            if (!(phase_q == PH_WAIT_CHK && !lastc_q)) begin
              if (ccnt_q >= CntW'(ChainedCapacity)) begin
                phase_d = PH_IDLE;
                hcnt_d = 2'd0;
                job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b1, ST_TOO_LONG);
              end else begin
                ccnt_d = ccnt_q + CntW'(1);
                job.res[0] = mk(KIND_PAYLOAD, h0_q, 1'b0, ST_ACKED);
              end
              n = 3'd1;
            end
          end
        end
      end
      default: begin
        if (phase_q == PH_WAIT_CHK || phase_q == PH_WAIT_GET) begin
          ok = (h0_q == SW1_OK) && (h1_q == BYTE_ZERO);
          n = 3'd1;
          if (!transport_ok_i || hcnt_q != 2'd2) begin
            phase_d = PH_IDLE;
            hcnt_d = 2'd0;
            job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b1, ST_LINK);
          end else if (phase_q == PH_WAIT_CHK && !lastc_q) begin
            if (!ok) begin
              phase_d = PH_IDLE;
              hcnt_d = 2'd0;
              job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b1, ST_BAD_SW);
            end else begin
              hcnt_d = 2'd0;
              job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b0, ST_ACKED);
              sc = 1'b1;
            end
          end else if (ok) begin
            phase_d = PH_IDLE;
            hcnt_d = 2'd0;
            job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b1, ST_COMPLETE);
          end else if (h0_q == SW1_MORE) begin
            le = (h1_q == 8'd0 || h1_q > max_rx_q) ? max_rx_q : h1_q;
            job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b0, ST_GETRSP);
            job.res[1] = mk(KIND_FRAME, BYTE_ZERO, 1'b0, ST_ACKED);
            job.res[2] = mk(KIND_FRAME, INS_GET, 1'b0, ST_ACKED);
            job.res[3] = mk(KIND_FRAME, BYTE_ZERO, 1'b0, ST_ACKED);
            job.res[4] = mk(KIND_FRAME, BYTE_ZERO, 1'b0, ST_ACKED);
            job.res[5] = mk(KIND_FRAME, le, 1'b1, ST_ACKED);
            n = 3'd6;
            phase_d = PH_WAIT_GET;
            hcnt_d = 2'd0;
          end else begin
            phase_d = PH_IDLE;
            hcnt_d = 2'd0;
            job.res[0] = mk(KIND_STATUS, BYTE_ZERO, 1'b1, ST_BAD_SW);
          end
        end
      end
    endcase
    // chunk header, appended after any status already queued
    if (sc) begin
      rem = total_d - sent_d;
      if (max_tx_q == 8'd0 || rem == 16'd0) begin
        phase_d = PH_IDLE;
        hcnt_d = 2'd0;
        job.res[n] = mk(KIND_STATUS, BYTE_ZERO, 1'b1, ST_BAD_CFG);
        n = n + 3'd1;
      end else begin
        chunk = (rem < {8'd0, max_tx_q}) ? rem[7:0] : max_tx_q;
        lc = ({8'd0, chunk} == rem);
        lastc_d = lc;
        left_d = chunk;
        phase_d = PH_COLLECT;
        job.res[n]        = mk(KIND_FRAME, lc ? CLA_LAST : CLA_CHAIN, 1'b0, ST_ACKED);
        job.res[n + 3'd1] = mk(KIND_FRAME, INS_XFER, 1'b0, ST_ACKED);
        job.res[n + 3'd2] = mk(KIND_FRAME, total_d[15:8], 1'b0, ST_ACKED);
        job.res[n + 3'd3] = mk(KIND_FRAME, total_d[7:0], 1'b0, ST_ACKED);
        job.res[n + 3'd4] = mk(KIND_FRAME, chunk, 1'b0, ST_ACKED);
        n = n + 3'd5;
      end
    end
    job.count = n;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tx_q <= 8'd255;
      max_rx_q <= 8'd255;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MAX_TX) max_tx_q <= cfg_data_i;
      else                         max_rx_q <= cfg_data_i;
    end
  end

  // protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      total_q <= '0;
      sent_q  <= '0;
      left_q  <= '0;
      lastc_q <= 1'b0;
      h0_q    <= '0;
      h1_q    <= '0;
      hcnt_q  <= '0;
      ccnt_q  <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      total_q <= total_d;
      sent_q  <= sent_d;
      left_q  <= left_d;
      lastc_q <= lastc_d;
      h0_q    <= h0_d;
      h1_q    <= h1_d;
      hcnt_q  <= hcnt_d;
      ccnt_q  <= ccnt_d;
    end
  end

endmodule

// ===== hdl/ace_back.sv =====
// back part: job queue and serializer of results onto the output stream
module ace_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  ace_pkg::job_t  job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ace_pkg::res_t  out_res_o
);
  import ace_pkg::*;

  localparam int unsigned Depth = 2;

  job_t       mem_q [Depth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [2:0] idx_q;
  logic       push, pop, take;

  assign job_ready_o = (cnt_q < 2'(Depth)) || pop;
  assign push        = job_valid_i && job_ready_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_res_o   = mem_q[rp_q].res[idx_q];
  assign take        = out_valid_o && out_ready_i;
  assign pop         = take && (idx_q + 3'd1 == mem_q[rp_q].count);

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job_i;
  end

  // queue pointers and serializer index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) begin
        rp_q  <= ~rp_q;
        idx_q <= '0;
      end else if (take) begin
        idx_q <= idx_q + 3'd1;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/ace_checker.sv =====
// port-level checks of the apdu chaining engine, bound to the top level
module ace_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [4:0] m_axis_tuser
);
  import ace_pkg::*;

  // status results carry a zero byte
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == KIND_STATUS |-> m_axis_tdata == BYTE_ZERO)
    else $error("status with nonzero byte");

  // payload never marked last
  a_payload_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == KIND_PAYLOAD |-> !m_axis_tlast)
    else $error("payload marked last");

  // stalled output holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

endmodule

bind apdu_chaining_engine_top ace_checker u_ace_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
  .m_axis_tlast, .m_axis_tuser
);

// ===== dv/testbench.sv =====
// self-checking testbench for the apdu chaining engine top level
module testbench;
  import ace_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // data_byte, message_length, transport_ok, zeros
  logic [1:0]  s_axis_tuser = '0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // out_byte
  logic        m_axis_tlast;       // out_last
  logic [4:0]  m_axis_tuser;       // out_kind, status

  apdu_chaining_engine_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  b;
    logic [15:0] len;
    logic        ok;
  } apdu_in_t;

  // engine mirror
  logic [7:0]  m_tx, m_rx;
  phase_e      ph;
  logic [15:0] tot_len, sent;
  logic [7:0]  chunk_left;
  logic        last_chunk;
  logic [7:0]  hold0, hold1;
  int          hold_n;
  int          fwd_cnt;

  res_t expected_q[$];
  int   n_fail = 0;
  int   n_res = 0;
  int   n_status = 0;
  int   q_mark = 0;
  bit   quiet = 0;
  bit   hold_off = 0;

  task automatic push(logic [1:0] k, logic [7:0] d, logic l, logic [2:0] s);
    expected_q.push_back(mk(k, d, l, s));
  endtask

  task automatic end_run(logic [2:0] s);
    ph = PH_IDLE;
    hold_n = 0;
    push(KIND_STATUS, 8'h00, 1'b1, s);
  endtask

  task automatic open_chunk();
    logic [15:0] rem;
    logic [7:0]  c;
    rem = tot_len - sent;
    if (m_tx == 0 || rem == 0) begin
      end_run(ST_BAD_CFG);
      return;
    end
    c = (rem < m_tx) ? rem[7:0] : m_tx;
    last_chunk = (c == rem);
    chunk_left = c;
    ph = PH_COLLECT;
    push(KIND_FRAME, last_chunk ? CLA_LAST : CLA_CHAIN, 1'b0, ST_ACKED);
    push(KIND_FRAME, INS_XFER, 1'b0, ST_ACKED);
    push(KIND_FRAME, tot_len[15:8], 1'b0, ST_ACKED);
    push(KIND_FRAME, tot_len[7:0], 1'b0, ST_ACKED);
    push(KIND_FRAME, c, 1'b0, ST_ACKED);
  endtask

  // works out the transfers one input item produces
  task automatic predict_apdu(apdu_in_t it);
    logic [7:0] old, le;
    bit good;
    case (it.act)
      ACT_START: begin
        hold_n = 0; fwd_cnt = 0; sent = '0; tot_len = it.len;
        if (m_tx == 0 || m_rx == 0 || it.len == 0) end_run(ST_BAD_CFG);
        else open_chunk();
      end
      ACT_MSG_BYTE: if (ph == PH_COLLECT) begin
        sent++;
        if (chunk_left > 0) chunk_left--;
        push(KIND_FRAME, it.b, 1'b0, ST_ACKED);
        if (chunk_left == 0) begin
          push(KIND_FRAME, m_rx, 1'b1, ST_ACKED);
          ph = PH_WAIT_CHK;
          hold_n = 0;
        end
      end
      ACT_RSP_BYTE: if (ph == PH_WAIT_CHK || ph == PH_WAIT_GET) begin
        if (hold_n < 2) begin
          if (hold_n == 0) hold0 = it.b; else hold1 = it.b;
          hold_n++;
        end else begin
          old = hold0; hold0 = hold1; hold1 = it.b;
          if (!(ph == PH_WAIT_CHK && !last_chunk)) begin
            if (fwd_cnt >= CHAINED_CAPACITY_DEF) end_run(ST_TOO_LONG);
            else begin
              fwd_cnt++;
              push(KIND_PAYLOAD, old, 1'b0, ST_ACKED);
            end
          end
        end
      end
      default: if (ph == PH_WAIT_CHK || ph == PH_WAIT_GET) begin
        good = (hold0 == SW1_OK && hold1 == BYTE_ZERO);
        if (!it.ok || hold_n < 2) end_run(ST_LINK);
        else if (ph == PH_WAIT_CHK && !last_chunk) begin
          if (!good) end_run(ST_BAD_SW);
          else begin
            hold_n = 0;
            push(KIND_STATUS, 8'h00, 1'b0, ST_ACKED);
            open_chunk();
          end
        end else if (good) end_run(ST_COMPLETE);
        else if (hold0 == SW1_MORE) begin
          le = (hold1 == 0 || hold1 > m_rx) ? m_rx : hold1;
          push(KIND_STATUS, 8'h00, 1'b0, ST_GETRSP);
          push(KIND_FRAME, BYTE_ZERO, 1'b0, ST_ACKED);
          push(KIND_FRAME, INS_GET, 1'b0, ST_ACKED);
          push(KIND_FRAME, BYTE_ZERO, 1'b0, ST_ACKED);
          push(KIND_FRAME, BYTE_ZERO, 1'b0, ST_ACKED);
          push(KIND_FRAME, le, 1'b1, ST_ACKED);
          ph = PH_WAIT_GET;
          hold_n = 0;
        end else end_run(ST_BAD_SW);
      end
    endcase
  endtask

  // sender: one transfer, random idle bursts before it, valid stays up afterwards
  task automatic send(apdu_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.act;
    s_axis_tdata  <= {7'd0, it.ok, it.len, it.b};
    do @(posedge clk_i); while (!s_axis_tready);
    q_mark = expected_q.size();
    predict_apdu(it);
  endtask

  function automatic apdu_in_t mk_in(logic [1:0] a, logic [7:0] b, logic [15:0] l, logic o);
    apdu_in_t r;
    r.act = a; r.b = b; r.len = l; r.ok = o;
    return r;
  endfunction

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MAX_TX) m_tx = v; else m_rx = v;
    @(posedge clk_i);
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tuser[1:0], m_axis_tdata, m_axis_tlast, m_axis_tuser[4:2]);
      n_res++;
      if (got.kind == KIND_STATUS) n_status++;
      if (expected_q.size() == 0) begin
        $error("unexpected transfer kind %0d data %h", got.kind, got.data);
        n_fail++;
      end else begin
        want = expected_q.pop_front();
        if (got.kind != want.kind) begin
          $error("out_kind expected %0d actual %0d", want.kind, got.kind); n_fail++;
        end
        if (got.data != want.data) begin
          $error("out_byte expected %h actual %h", want.data, got.data); n_fail++;
        end
        if (got.last != want.last) begin
          $error("out_last expected %0d actual %0d", want.last, got.last); n_fail++;
        end
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); n_fail++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int k;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        for (k = 0; k < 60; k++) @(posedge clk_i);
        hold_off = 0;
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt > 2000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // sends one full message with random content and tag answers
  task automatic run_message(int len, int mode);
    int pos, c, i, pay;
    logic [7:0] sw2;
    send(mk_in(ACT_START, 8'($urandom), len[15:0], 1'($urandom)));
    pos = 0;
    while (pos < len && m_tx != 0) begin
      c = (len - pos < m_tx) ? len - pos : m_tx;
      for (i = 0; i < c; i++)
        send(mk_in(ACT_MSG_BYTE, 8'($urandom), 16'($urandom), 1'($urandom)));
      pos += c;
      if (pos < len) begin
        if ($urandom_range(0, 2) == 0)
          send(mk_in(ACT_RSP_BYTE, 8'($urandom), 16'($urandom), 1'($urandom)));
        send(mk_in(ACT_RSP_BYTE, SW1_OK, 16'($urandom), 1'($urandom)));
        send(mk_in(ACT_RSP_BYTE, BYTE_ZERO, 16'($urandom), 1'($urandom)));
        send(mk_in(ACT_RSP_END, 8'($urandom), 16'($urandom), 1'b1));
      end
    end
    pay = $urandom_range(0, 4);
    for (i = 0; i < pay; i++)
      send(mk_in(ACT_RSP_BYTE, 8'($urandom), 16'($urandom), 1'($urandom)));
    sw2 = 8'($urandom);
    case (mode)
      0: begin
        send(mk_in(ACT_RSP_BYTE, SW1_OK, 16'd0, 1'b0));
        send(mk_in(ACT_RSP_BYTE, BYTE_ZERO, 16'd0, 1'b0));
      end
      1: begin
        send(mk_in(ACT_RSP_BYTE, SW1_MORE, 16'd0, 1'b0));
        send(mk_in(ACT_RSP_BYTE, sw2, 16'd0, 1'b0));
        send(mk_in(ACT_RSP_END, 8'h00, 16'd0, 1'b1));
        for (i = 0; i < pay; i++)
          send(mk_in(ACT_RSP_BYTE, 8'($urandom), 16'($urandom), 1'($urandom)));
        send(mk_in(ACT_RSP_BYTE, SW1_OK, 16'd0, 1'b0));
        send(mk_in(ACT_RSP_BYTE, BYTE_ZERO, 16'd0, 1'b0));
      end
      default: send(mk_in(ACT_RSP_BYTE, 8'($urandom), 16'($urandom), 1'($urandom)));
    endcase
    send(mk_in(ACT_RSP_END, 8'($urandom), 16'($urandom), $urandom_range(0, 7) != 0));
  endtask

  typedef struct {
    apdu_in_t it;
    bit       has_exp;
    res_t     exp0;
  } row_t;

  initial begin
    row_t rows[$];
    row_t r;
    int i;
    m_tx = 8'd255; m_rx = 8'd255; ph = PH_IDLE; tot_len = '0; sent = '0; chunk_left = '0;
    last_chunk = 1'b0; hold0 = '0; hold1 = '0; hold_n = 0; fwd_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: first expected result typed in where obvious
    r.has_exp = 1'b1; r.it = mk_in(ACT_START, 8'hFF, 16'd0, 1'b1);
    r.exp0 = mk(KIND_STATUS, 8'h00, 1'b1, ST_BAD_CFG); rows.push_back(r);
    r.it = mk_in(ACT_MSG_BYTE, 8'hAA, 16'hFFFF, 1'b1); r.has_exp = 1'b0; rows.push_back(r);
    r.it = mk_in(ACT_RSP_END, 8'h00, 16'h0, 1'b1); rows.push_back(r);
    r.has_exp = 1'b1; r.it = mk_in(ACT_START, 8'h00, 16'hFFFF, 1'b0);
    r.exp0 = mk(KIND_FRAME, CLA_CHAIN, 1'b0, ST_ACKED); rows.push_back(r);
    r.it = mk_in(ACT_START, 8'h00, 16'd2, 1'b0);
    r.exp0 = mk(KIND_FRAME, CLA_LAST, 1'b0, ST_ACKED); rows.push_back(r);
    r.has_exp = 1'b0;
    r.it = mk_in(ACT_MSG_BYTE, 8'h00, 16'd0, 1'b0); rows.push_back(r);
    r.it = mk_in(ACT_MSG_BYTE, 8'hFF, 16'd0, 1'b0); rows.push_back(r);
    r.it = mk_in(ACT_RSP_BYTE, 8'h90, 16'd0, 1'b0); rows.push_back(r);
    r.has_exp = 1'b1; r.it = mk_in(ACT_RSP_END, 8'h00, 16'd0, 1'b1);
    r.exp0 = mk(KIND_STATUS, 8'h00, 1'b1, ST_LINK); rows.push_back(r);
    r.it = mk_in(ACT_START, 8'h00, 16'd1, 1'b0); r.has_exp = 1'b0; rows.push_back(r);
    r.it = mk_in(ACT_MSG_BYTE, 8'h5A, 16'd0, 1'b0); rows.push_back(r);
    r.it = mk_in(ACT_RSP_BYTE, 8'h12, 16'd0, 1'b0); rows.push_back(r);
    r.it = mk_in(ACT_RSP_BYTE, 8'h34, 16'd0, 1'b0); rows.push_back(r);
    r.has_exp = 1'b1; r.it = mk_in(ACT_RSP_END, 8'h00, 16'd0, 1'b0);
    r.exp0 = mk(KIND_STATUS, 8'h00, 1'b1, ST_LINK); rows.push_back(r);
    r.it = mk_in(ACT_START, 8'h00, 16'd1, 1'b1); r.has_exp = 1'b0; rows.push_back(r);
    r.it = mk_in(ACT_MSG_BYTE, 8'h5A, 16'd0, 1'b0); rows.push_back(r);
    r.it = mk_in(ACT_RSP_BYTE, 8'h6A, 16'd0, 1'b0); rows.push_back(r);
    r.it = mk_in(ACT_RSP_BYTE, 8'h82, 16'd0, 1'b0); rows.push_back(r);
    r.has_exp = 1'b1; r.it = mk_in(ACT_RSP_END, 8'h00, 16'd0, 1'b1);
    r.exp0 = mk(KIND_STATUS, 8'h00, 1'b1, ST_BAD_SW); rows.push_back(r);

    foreach (rows[j]) begin
      send(rows[j].it);
      if (rows[j].has_exp && expected_q[q_mark] != rows[j].exp0) begin
        $error("directed row %0d status expected %0d actual %0d",
               j, rows[j].exp0.status, expected_q[q_mark].status);
        n_fail++;
      end
    end
    // start while busy, get response chains
    run_message(3, 1);
    send(mk_in(ACT_START, 8'h00, 16'd4, 1'b1));
    send(mk_in(ACT_MSG_BYTE, 8'h01, 16'd0, 1'b0));
    run_message(2, 1);
    wait_drain();

    // configuration sweep with random messages
    for (i = 0; i < 10; i++) begin
      case (i)
        0: begin write_reg(REG_MAX_TX, 8'd0); write_reg(REG_MAX_RX, 8'd255); end
        1: begin write_reg(REG_MAX_TX, 8'd1); write_reg(REG_MAX_RX, 8'd0); end
        2: begin write_reg(REG_MAX_TX, 8'd1); write_reg(REG_MAX_RX, 8'd1); end
        3: begin write_reg(REG_MAX_TX, 8'd255); write_reg(REG_MAX_RX, 8'd255); end
        default: begin
          write_reg(REG_MAX_TX, 8'($urandom_range(1, 4)));
          write_reg(REG_MAX_RX, 8'($urandom));
        end
      endcase
      if (i == 5) hold_off = 1;
      if (i == 8) quiet = 1;
      run_message($urandom_range(1, 5), $urandom_range(0, 2));
      if ($urandom_range(0, 1))
        send(mk_in(2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom)));
      wait_drain();
    end

    $display("run covered directed edge cases and 10 register settings");
    $display("%0d output transfers checked, %0d of them status", n_res, n_status);
    if (n_fail == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ace_pkg.sv
hdl/ace_front.sv
hdl/ace_back.sv
hdl/apdu_chaining_engine_top.sv
hdl/ace_checker.sv
dv/testbench.sv
